@@ rtl/jqcp_pkg.sv @@
// shared types, constants and command/status structs for the job queue
package jqcp_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned NAME_CHARS = 14;
  localparam int unsigned KEY_CHARS  = 14;
  localparam int unsigned KEY_BITS   = 8 * KEY_CHARS;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned SIZE_W     = 14;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 14'd9999;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_TAKE    = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_PROMOTE = 3'd3,
    OP_LIST    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REFUSED   = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [63:0]       key_high;
    logic [47:0]       key_low;
    logic [SIZE_W-1:0] job_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [63:0]       out_key_high;
    logic [47:0]       out_key_low;
    logic [SIZE_W-1:0] out_size;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [63:0]       name_high;
    logic [47:0]       name_low;
    logic [SIZE_W-1:0] size;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_ZERO   = 3'd1,
    RD_IDX_P1 = 3'd2,
    RD_IDX_P2 = 3'd3,
    RD_IDX_M1 = 3'd4,
    RD_IDX_M2 = 3'd5
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_APPEND = 2'd1,
    WR_SHIFT  = 2'd2,
    WR_PLACE  = 2'd3
  } wr_sel_e;

  typedef enum logic [1:0] {
    IDX_KEEP = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2,
    IDX_DEC  = 2'd3
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef enum logic [1:0] {
    HOLD_KEEP  = 2'd0,
    HOLD_KEY   = 2'd1,
    HOLD_RDATA = 2'd2,
    HOLD_CLR   = 2'd3
  } hold_op_e;

  typedef enum logic {
    OUT_HOLD  = 1'b0,
    OUT_RDATA = 1'b1
  } out_src_e;

  typedef struct packed {
    logic     in_load;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    idx_op_e  idx_op;
    cnt_op_e  cnt_op;
    hold_op_e hold_op;
    logic     out_load;
    out_src_e out_src;
    status_e  status;
    logic     last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       match;
    logic       idx_lt2;
    logic       idx_gt2;
    logic       idx_last;
    logic       idx2_end;
    logic       out_free;
  } dp_stat_t;

endpackage

@@ rtl/jqcp_ram.sv @@
// generic single write port, single read port ram with registered read
module jqcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ rtl/jqcp_dp.sv @@
// datapath: input latch, entry store, pointers, compare and output register
module jqcp_dp import jqcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o
);

  logic [2:0]          op_q;
  entry_t              key_q, key_d;
  entry_t              hold_q;
  entry_t              rd_data;
  entry_t              wr_data;
  logic [CW-1:0]       count_q;
  logic [AW-1:0]       idx_q;
  logic                out_valid_q;
  out_item_t           out_q, out_d;
  logic [KEY_BITS-1:0] name_c;
  logic                ended;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  entry_t              out_src;

  // name normalizing: every char after the first nul, or beyond NAME_CHARS, is zero
  always_comb begin
    name_c = {in_item_i.key_high, in_item_i.key_low};
    ended  = 1'b0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (i >= NAME_CHARS || name_c[KEY_BITS-1-8*i -: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (ended) begin
        name_c[KEY_BITS-1-8*i -: 8] = 8'd0;
      end
    end
    key_d.name_high = name_c[KEY_BITS-1 -: 64];
    key_d.name_low  = name_c[47:0];
    key_d.size      = (in_item_i.job_size > SIZE_MAX) ? SIZE_MAX : in_item_i.job_size;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q  <= in_item_i.op;
      key_q <= key_d;
    end
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = idx_q;
    case (cmd_i.rd_sel)
      RD_ZERO:   rd_addr = '0;
      RD_IDX_P1: rd_addr = idx_q + AW'(1);
      RD_IDX_P2: rd_addr = idx_q + AW'(2);
      RD_IDX_M1: rd_addr = idx_q - AW'(1);
      RD_IDX_M2: rd_addr = idx_q - AW'(2);
      default:   rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_q;
    wr_data = rd_data;
    case (cmd_i.wr_sel)
      WR_APPEND: begin
        wr_addr = count_q[AW-1:0];
        wr_data = key_q;
      end
      WR_SHIFT: begin
        wr_addr = idx_q;
        wr_data = rd_data;
      end
      WR_PLACE: begin
        wr_addr = AW'(1);
        wr_data = hold_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  jqcp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      case (cmd_i.cnt_op)
        CNT_INC: count_q <= count_q + CW'(1);
        CNT_DEC: count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
      case (cmd_i.idx_op)
        IDX_CLR: idx_q <= '0;
        IDX_INC: idx_q <= idx_q + AW'(1);
        IDX_DEC: idx_q <= idx_q - AW'(1);
        default: idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.hold_op)
      HOLD_KEY:   hold_q <= key_q;
      HOLD_RDATA: hold_q <= rd_data;
      HOLD_CLR:   hold_q <= '0;
      default:    hold_q <= hold_q;
    endcase
  end

  assign out_src = (cmd_i.out_src == OUT_RDATA) ? rd_data : hold_q;

  always_comb begin
    out_d.status       = cmd_i.status;
    out_d.out_key_high = out_src.name_high;
    out_d.out_key_low  = out_src.name_low;
    out_d.out_size     = out_src.size;
    out_d.occupancy    = OCC_W'(count_q);
    out_d.last         = cmd_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    stat_o.op       = op_q;
    stat_o.full     = (count_q == CW'(DEPTH));
    stat_o.empty    = (count_q == '0);
    stat_o.match    = (rd_data.name_high == key_q.name_high) &&
                      (rd_data.name_low == key_q.name_low);
    stat_o.idx_lt2  = (idx_q < AW'(2));
    stat_o.idx_gt2  = (idx_q > AW'(2));
    stat_o.idx_last = ((CW'(idx_q) + CW'(1)) == count_q);
    stat_o.idx2_end = ((CW'(idx_q) + CW'(2)) >= count_q);
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule

@@ rtl/jqcp_ctrl.sv @@
// controller: sequences one operation at a time over the entry store
module jqcp_ctrl import jqcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_SEARCH = 8'b0000_0100,
    S_REM    = 8'b0000_1000,
    S_PRO    = 8'b0001_0000,
    S_PLACE  = 8'b0010_0000,
    S_LIST   = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  op_e     op;

  assign op = op_e'(stat_i.op);

  always_comb begin
    state_d        = state_q;
    status_d       = status_q;
    cmd_o.in_load  = 1'b0;
    cmd_o.rd_sel   = RD_NONE;
    cmd_o.wr_sel   = WR_NONE;
    cmd_o.idx_op   = IDX_KEEP;
    cmd_o.cnt_op   = CNT_KEEP;
    cmd_o.hold_op  = HOLD_KEEP;
    cmd_o.out_load = 1'b0;
    cmd_o.out_src  = OUT_HOLD;
    cmd_o.status   = ST_OK;
    cmd_o.last     = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          cmd_o.idx_op  = IDX_CLR;
          state_d       = S_DECODE;
        end
      end

      S_DECODE: begin
        case (op)
          OP_APPEND: begin
            if (stat_i.full) begin
              status_d      = ST_FULL;
              cmd_o.hold_op = HOLD_CLR;
            end else begin
              status_d      = ST_OK;
              cmd_o.wr_sel  = WR_APPEND;
              cmd_o.cnt_op  = CNT_INC;
              cmd_o.hold_op = HOLD_KEY;
            end
            state_d = S_RESULT;
          end
          OP_TAKE, OP_CANCEL, OP_PROMOTE, OP_LIST: begin
            if (stat_i.empty) begin
              status_d      = (op inside {OP_TAKE, OP_LIST}) ? ST_EMPTY : ST_NOT_FOUND;
              cmd_o.hold_op = HOLD_CLR;
              state_d       = S_RESULT;
            end else begin
              cmd_o.rd_sel = RD_ZERO;
              state_d      = (op == OP_LIST) ? S_LIST : S_SEARCH;
            end
          end
          default: begin
            status_d      = ST_OK;
            cmd_o.hold_op = HOLD_CLR;
            state_d       = S_RESULT;
          end
        endcase
      end

      // take head is a search that hits at the first entry
      S_SEARCH: begin
        if (op == OP_TAKE || stat_i.match) begin
          cmd_o.hold_op = HOLD_RDATA;
          if (op == OP_PROMOTE) begin
            if (stat_i.idx_lt2) begin
              status_d = ST_REFUSED;
              state_d  = S_RESULT;
            end else begin
              cmd_o.rd_sel = RD_IDX_M1;
              state_d      = S_PRO;
            end
          end else if (stat_i.idx_last) begin
            status_d     = ST_OK;
            cmd_o.cnt_op = CNT_DEC;
            state_d      = S_RESULT;
          end else begin
            cmd_o.rd_sel = RD_IDX_P1;
            state_d      = S_REM;
          end
        end else if (stat_i.idx_last) begin
          status_d      = ST_NOT_FOUND;
          cmd_o.hold_op = HOLD_CLR;
          state_d       = S_RESULT;
        end else begin
          cmd_o.rd_sel = RD_IDX_P1;
          cmd_o.idx_op = IDX_INC;
        end
      end

      // close the gap: entry idx+1 moves to idx, next read runs one ahead
      S_REM: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_INC;
        if (stat_i.idx2_end) begin
          status_d     = ST_OK;
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_RESULT;
        end else begin
          cmd_o.rd_sel = RD_IDX_P2;
        end
      end

      // open a slot at place 1: entry idx-1 moves to idx
      S_PRO: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_DEC;
        if (stat_i.idx_gt2) begin
          cmd_o.rd_sel = RD_IDX_M2;
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        cmd_o.wr_sel = WR_PLACE;
        status_d     = ST_OK;
        state_d      = S_RESULT;
      end

      S_LIST: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = OUT_RDATA;
          cmd_o.status   = ST_OK;
          cmd_o.last     = stat_i.idx_last;
          if (stat_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = IDX_INC;
            cmd_o.rd_sel = RD_IDX_P1;
          end
        end
      end

      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = OUT_HOLD;
          cmd_o.status   = status_q;
          cmd_o.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ rtl/job_queue_cancel_promote_unit.sv @@
// top level of the bounded job queue with cancel and promote by name
// usage:
//  - input channel (in_valid_i / in_stall_o / in_item_i) carries one command
//    per transaction: append, take head, cancel by name, promote by name, list
//  - output channel (out_valid_o / out_stall_i / out_item_o) carries results;
//    every command gives one result, list gives one per stored job, and the
//    last flag marks the final result of a command
//  - one command is worked on at a time; in_stall_o is high from the cycle
//    after acceptance until the command's last result is in the output register
//  - the time a command takes grows with the entries searched, the entries
//    moved and, for list, the stored jobs; the walk over the entry store (one
//    ram read and write a cycle) sets it, so the worst case is promote of the
//    tail of a full queue
//  - a finished result sits in the output register, so the next command is
//    accepted while it waits; a stalled receiver holds the result steady and
//    pauses the list walk and the final result step of the next command
//  - reset clears the entry count and the controller; the store itself is not
//    cleared, entries beyond the count are never read
module job_queue_cancel_promote_unit import jqcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decides each step from datapath status
  jqcp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // store, pointers, name compare and result register
  jqcp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

@@ verif/job_queue_cancel_promote_unit_test.sv @@
// self-checking testbench for the job queue with cancel and promote by name
module job_queue_cancel_promote_unit_test import jqcp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_SIZE     = 6;
  localparam int unsigned RANDOM_ITEMS  = 240;
  localparam int unsigned CALM_TAIL     = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_e;

  // mirror of the job queue: applies each accepted command and keeps the
  // results it must produce, in order
  class job_queue_mirror;
    logic [KEY_BITS-1:0] names [DEPTH];
    logic [SIZE_W-1:0]   sizes [DEPTH];
    int                  count;
    out_item_t           awaited [$];
    int unsigned         faults;

    function new();
      count  = 0;
      faults = 0;
    endfunction

    // a name ends at its first zero character
    function logic [KEY_BITS-1:0] normalise(logic [KEY_BITS-1:0] nm);
      bit ended;
      int i;
      ended = 1'b0;
      for (i = 0; i < KEY_CHARS; i++) begin
        if (i >= NAME_CHARS) ended = 1'b1;
        if (!ended && nm[KEY_BITS-1-8*i -: 8] == 8'd0) ended = 1'b1;
        if (ended) nm[KEY_BITS-1-8*i -: 8] = 8'd0;
      end
      return nm;
    endfunction

    function void await_result(status_e st, logic [KEY_BITS-1:0] nm,
                               logic [SIZE_W-1:0] sz, logic fin);
      out_item_t r;
      r.status                      = st;
      {r.out_key_high, r.out_key_low} = nm;
      r.out_size                    = sz;
      r.occupancy                   = OCC_W'(count);
      r.last                        = fin;
      awaited.push_back(r);
    endfunction

    function int find_name(logic [KEY_BITS-1:0] nm);
      int i;
      for (i = 0; i < count; i++)
        if (names[i] == nm) return i;
      return -1;
    endfunction

    function void drop_entry(int idx);
      int i;
      for (i = idx; i + 1 < count; i++) begin
        names[i] = names[i+1];
        sizes[i] = sizes[i+1];
      end
      count--;
    endfunction

    function void note_command(in_item_t it);
      logic [KEY_BITS-1:0] nm;
      logic [KEY_BITS-1:0] hit_nm;
      logic [SIZE_W-1:0]   sz;
      logic [SIZE_W-1:0]   hit_sz;
      int                  idx;
      int                  i;
      nm  = normalise({it.key_high, it.key_low});
      sz  = (it.job_size > SIZE_MAX) ? SIZE_MAX : it.job_size;
      idx = find_name(nm);
      case (it.op)
        OP_APPEND: begin
          if (count >= DEPTH) begin
            await_result(ST_FULL, '0, '0, 1'b1);
          end else begin
            names[count] = nm;
            sizes[count] = sz;
            count++;
            await_result(ST_OK, nm, sz, 1'b1);
          end
        end
        OP_TAKE: begin
          if (count == 0) begin
            await_result(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            hit_nm = names[0];
            hit_sz = sizes[0];
            drop_entry(0);
            await_result(ST_OK, hit_nm, hit_sz, 1'b1);
          end
        end
        OP_CANCEL: begin
          if (idx < 0) begin
            await_result(ST_NOT_FOUND, '0, '0, 1'b1);
          end else begin
            hit_nm = names[idx];
            hit_sz = sizes[idx];
            drop_entry(idx);
            await_result(ST_OK, hit_nm, hit_sz, 1'b1);
          end
        end
        OP_PROMOTE: begin
          if (idx < 0) begin
            await_result(ST_NOT_FOUND, '0, '0, 1'b1);
          end else if (idx < 2) begin
            await_result(ST_REFUSED, names[idx], sizes[idx], 1'b1);
          end else begin
            hit_nm = names[idx];
            hit_sz = sizes[idx];
            for (i = idx; i > 1; i--) begin
              names[i] = names[i-1];
              sizes[i] = sizes[i-1];
            end
            names[1] = hit_nm;
            sizes[1] = hit_sz;
            await_result(ST_OK, hit_nm, hit_sz, 1'b1);
          end
        end
        OP_LIST: begin
          if (count == 0) begin
            await_result(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            for (i = 0; i < count; i++)
              await_result(ST_OK, names[i], sizes[i], i == count - 1);
          end
        end
        default: begin
          await_result(ST_OK, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function string show(out_item_t r);
      return $sformatf("status %0d key %h_%h size %0d occupancy %0d last %0b",
                       r.status, r.out_key_high, r.out_key_low, r.out_size,
                       r.occupancy, r.last);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     diffs;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT) $display("result with nothing awaited: %s", show(got));
        return;
      end
      want  = awaited.pop_front();
      diffs = "";
      if (got.status !== want.status)             diffs = {diffs, " status"};
      if (got.out_key_high !== want.out_key_high) diffs = {diffs, " out_key_high"};
      if (got.out_key_low !== want.out_key_low)   diffs = {diffs, " out_key_low"};
      if (got.out_size !== want.out_size)         diffs = {diffs, " out_size"};
      if (got.occupancy !== want.occupancy)       diffs = {diffs, " occupancy"};
      if (got.last !== want.last)                 diffs = {diffs, " last"};
      if (diffs != "") begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("mismatch in%s", diffs);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  job_queue_mirror     mirror;
  logic [KEY_BITS-1:0] name_pool [POOL_SIZE];
  bit                  calm;          // no idling on either side
  bit                  hold_off_req;  // asks the receiver for one long stall
  int unsigned         sent;
  int unsigned         cycles;

  job_queue_cancel_promote_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("job_queue_cancel_promote_unit_test failed");
        $finish;
      end
    end
  end

  // every result transaction is checked against the oldest awaited one
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      mirror.check_result(out_item_o);
  end

  // receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b0;
        repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  function automatic in_item_t make_item(logic [2:0] op, logic [KEY_BITS-1:0] nm,
                                         logic [SIZE_W-1:0] sz);
    in_item_t it;
    it.op                      = op;
    {it.key_high, it.key_low} = nm;
    it.job_size                = sz;
    return it;
  endfunction

  // fill the characters after the terminator with garbage
  function automatic logic [KEY_BITS-1:0] smear_tail(logic [KEY_BITS-1:0] nm);
    bit ended;
    int i;
    ended = 1'b0;
    for (i = 0; i < KEY_CHARS; i++) begin
      if (ended) nm[KEY_BITS-1-8*i -: 8] = 8'($urandom);
      else if (nm[KEY_BITS-1-8*i -: 8] == 8'd0) ended = 1'b1;
    end
    return nm;
  endfunction

  // mostly pool names so that cancel and promote find matches
  function automatic logic [KEY_BITS-1:0] pick_name();
    logic [KEY_BITS-1:0] nm;
    int unsigned         roll;
    roll = $urandom_range(0, 99);
    nm   = name_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll >= 85) nm = {$urandom(), $urandom(), $urandom(), 16'($urandom())};
    else if (roll >= 70) nm = smear_tail(nm);
    return nm;
  endfunction

  function automatic in_item_t make_random_command(traffic_mix_e mix);
    int unsigned       roll;
    int unsigned       to_append;
    int unsigned       to_take;
    int unsigned       to_cancel;
    int unsigned       to_promote;
    int unsigned       to_list;
    logic [2:0]        op;
    logic [SIZE_W-1:0] sz;
    // cumulative odds in percent per operation
    case (mix)
      MIX_FILL: begin
        to_append = 65; to_take = 72; to_cancel = 80; to_promote = 90; to_list = 96;
      end
      MIX_DRAIN: begin
        to_append = 15; to_take = 45; to_cancel = 70; to_promote = 82; to_list = 92;
      end
      default: begin
        to_append = 35; to_take = 50; to_cancel = 65; to_promote = 80; to_list = 92;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < to_append)       op = OP_APPEND;
    else if (roll < to_take)    op = OP_TAKE;
    else if (roll < to_cancel)  op = OP_CANCEL;
    else if (roll < to_promote) op = OP_PROMOTE;
    else if (roll < to_list)    op = OP_LIST;
    else                        op = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) sz = SIZE_W'($urandom_range(10000, 16383));
    else                           sz = SIZE_W'($urandom_range(0, 9999));
    return make_item(op, pick_name(), sz);
  endfunction

  // offer one command and hold it until accepted, then maybe idle a while
  task automatic send_command(input in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    mirror.note_command(it);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // stop offering until every awaited result has come back
  task automatic drain_queue();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.awaited.size() != 0);
  endtask

  initial begin
    logic [KEY_BITS-1:0] nm;
    logic [KEY_BITS-1:0] absent_nm;
    int unsigned         len;
    int unsigned         round;
    int unsigned         round_len;
    int unsigned         random_target;
    traffic_mix_e        mix;
    int                  i;
    int                  k;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_stall_i  = 1'b0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    sent         = 0;
    mirror       = new();

    // printable names of full, single and random length
    for (k = 0; k < POOL_SIZE; k++) begin
      len = (k == 0) ? KEY_CHARS : (k == 1) ? 1 : $urandom_range(1, KEY_CHARS);
      nm  = '0;
      for (i = 0; i < len; i++) nm[KEY_BITS-1-8*i -: 8] = 8'($urandom_range(33, 126));
      name_pool[k] = nm;
    end
    // never equal to a pool name, which holds printable characters only
    absent_nm = '0;
    absent_nm[KEY_BITS-1 -: 16] = 16'hFFFE;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue cases
    send_command(make_item(OP_TAKE, '0, '0));
    send_command(make_item(OP_LIST, '0, '0));
    send_command(make_item(OP_CANCEL, name_pool[0], '0));
    send_command(make_item(OP_PROMOTE, name_pool[0], '0));
    // unused op codes above list
    for (k = 1; k <= 3; k++) send_command(make_item(OP_LIST + 3'(k), '1, '1));
    // extreme names and sizes, oversize saturates, garbage after terminator
    send_command(make_item(OP_APPEND, '1, '1));
    send_command(make_item(OP_APPEND, '0, '0));
    send_command(make_item(OP_APPEND, smear_tail(name_pool[1]), SIZE_MAX));
    send_command(make_item(OP_APPEND, name_pool[0], 14'd10000));
    send_command(make_item(OP_APPEND, name_pool[2], SIZE_W'($urandom_range(0, 9999))));
    send_command(make_item(OP_LIST, '0, '0));
    // promote refused for first and second place, allowed further back
    send_command(make_item(OP_PROMOTE, '1, '0));
    send_command(make_item(OP_PROMOTE, '0, '0));
    send_command(make_item(OP_PROMOTE, name_pool[2], '0));
    // cancel by clean name matches the stored normalised one
    send_command(make_item(OP_CANCEL, name_pool[1], '0));
    send_command(make_item(OP_CANCEL, absent_nm, '0));
    send_command(make_item(OP_PROMOTE, absent_nm, '0));
    send_command(make_item(OP_TAKE, '0, '0));
    send_command(make_item(OP_LIST, '0, '0));
    drain_queue();

    // random rounds: fill first so full shows up, then drain, then mixed;
    // the receiver holds off once while the sender keeps offering
    random_target = sent + RANDOM_ITEMS;
    round         = 0;
    while (sent < random_target) begin
      if (round == 0)      mix = MIX_FILL;
      else if (round == 1) mix = MIX_DRAIN;
      else                 mix = traffic_mix_e'($urandom_range(0, 2));
      if (round == 2) hold_off_req = 1'b1;
      round_len = $urandom_range(15, 40);
      for (k = 0; k < round_len && sent < random_target; k++) begin
        calm = (random_target - sent <= CALM_TAIL);
        send_command(make_random_command(mix));
      end
      if (!calm && $urandom_range(0, 2) == 0) drain_queue();
      round++;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.awaited.size() != 0);
    // catch any stray result after the last one
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mirror.faults == 0 && mirror.awaited.size() == 0) begin
      $display("job_queue_cancel_promote_unit_test passed");
    end else begin
      $display("job_queue_cancel_promote_unit_test failed");
    end
    $finish;
  end

endmodule
